// ===== rtl/ctblit_pkg.sv =====
// Shared types and constants for the clipped color-key blitter.
// Used by ctblit_front, ctblit_queue, ctblit_back and clipped_transparent_blit.
package ctblit_pkg;

  localparam int COORD_BITS = 12;
  localparam int SCR_BITS   = 12;
  localparam int PITCH_BITS = 13;
  localparam int ADDR_BITS  = 24;
  localparam int PIX_BITS   = 8;
  localparam int PROD_BITS  = SCR_BITS + PITCH_BITS;

  // signed screen coordinate width: origin plus count, with room for the sign
  localparam int XW = ((COORD_BITS > SCR_BITS) ? COORD_BITS : SCR_BITS) + 2;

  // queue depth, power of two
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = PITCH_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_W     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_H     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEST_PITCH = 2'd2;

  localparam logic [SCR_BITS-1:0]   RST_CLIP_W     = 12'd640;
  localparam logic [SCR_BITS-1:0]   RST_CLIP_H     = 12'd480;
  localparam logic [PITCH_BITS-1:0] RST_DEST_PITCH = 13'd640;

  typedef struct packed {
    logic [SCR_BITS-1:0]   clip_w;
    logic [SCR_BITS-1:0]   clip_h;
    logic [PITCH_BITS-1:0] dest_pitch;
  } cfg_t;

  // one clipped, visible pixel on its way to the address stage
  typedef struct packed {
    logic [SCR_BITS-1:0] x;
    logic [SCR_BITS-1:0] y;
    logic [PIX_BITS-1:0] pixel;
  } wr_t;

endpackage

// ===== rtl/clipped_transparent_blit.sv =====
// Top level of the clipped color-key 8bpp blitter: config registers and wiring.
// Depends on ctblit_pkg, ctblit_front, ctblit_queue and ctblit_back.
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | req_type, pos_x, pos_y, bmp_width, bmp_height, src_pixel
//   out     | out_valid / out_stall| write_address, write_data
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per clock while in_stall is low; a visible pixel passes the queue, stage A and the output register.
// The rate is set by the front end, which clips and steps the raster counters for each accepted item.
// in_stall rises only when the 4-entry queue in front of the multiply stage is full.
// Reset is synchronous: no active blit, screen 640x480, pitch 640. cfg_ready is always high.
module clipped_transparent_blit (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_req_type,
  input  logic signed [ctblit_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [ctblit_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic [ctblit_pkg::COORD_BITS-1:0]        in_bmp_width,
  input  logic [ctblit_pkg::COORD_BITS-1:0]        in_bmp_height,
  input  logic [ctblit_pkg::PIX_BITS-1:0]          in_src_pixel,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [ctblit_pkg::ADDR_BITS-1:0]         out_write_address,
  output logic [ctblit_pkg::PIX_BITS-1:0]          out_write_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [ctblit_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [ctblit_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import ctblit_pkg::*;

  cfg_t cfg_r;
  logic q_full, q_empty, push, pop;
  wr_t  push_item, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_w     <= RST_CLIP_W;
      cfg_r.clip_h     <= RST_CLIP_H;
      cfg_r.dest_pitch <= RST_DEST_PITCH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLIP_W:     cfg_r.clip_w     <= cfg_data[SCR_BITS-1:0];
        REG_CLIP_H:     cfg_r.clip_h     <= cfg_data[SCR_BITS-1:0];
        REG_DEST_PITCH: cfg_r.dest_pitch <= cfg_data[PITCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  ctblit_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_bmp_width  (in_bmp_width),
    .in_bmp_height (in_bmp_height),
    .in_src_pixel  (in_src_pixel),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  ctblit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ctblit_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data)
  );

endmodule

// ===== rtl/ctblit_front.sv =====
// Front end: accepts start and pixel items, tracks the raster position, clips.
// Depends on ctblit_pkg; pushes visible pixels into ctblit_queue.
module ctblit_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic signed [ctblit_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [ctblit_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic [ctblit_pkg::COORD_BITS-1:0]    in_bmp_width,
  input  logic [ctblit_pkg::COORD_BITS-1:0]    in_bmp_height,
  input  logic [ctblit_pkg::PIX_BITS-1:0]      in_src_pixel,
  input  ctblit_pkg::cfg_t                     cfg,
  input  logic                                 q_full,
  output logic                                 push,
  output ctblit_pkg::wr_t                      push_item
);
  import ctblit_pkg::*;

  logic                  active_r;
  logic [COORD_BITS-1:0] origin_x_r, origin_y_r;
  logic [COORD_BITS-1:0] size_w_r, size_h_r;
  logic [COORD_BITS-1:0] col_r, row_r;

  logic                  accept;
  logic [XW-1:0]         x_pos, y_pos;
  logic                  x_in, y_in;
  logic                  col_last, row_last;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign x_pos = {{(XW-COORD_BITS){origin_x_r[COORD_BITS-1]}}, origin_x_r}
               + {{(XW-COORD_BITS){1'b0}}, col_r};
  assign y_pos = {{(XW-COORD_BITS){origin_y_r[COORD_BITS-1]}}, origin_y_r}
               + {{(XW-COORD_BITS){1'b0}}, row_r};

  assign x_in = !x_pos[XW-1] && (x_pos < {{(XW-SCR_BITS){1'b0}}, cfg.clip_w});
  assign y_in = !y_pos[XW-1] && (y_pos < {{(XW-SCR_BITS){1'b0}}, cfg.clip_h});

  assign col_last = ({1'b0, col_r} + 1'b1) >= {1'b0, size_w_r};
  assign row_last = ({1'b0, row_r} + 1'b1) >= {1'b0, size_h_r};

  assign push = accept && (in_req_type == REQ_PIXEL) && active_r &&
                (in_src_pixel != '0) && x_in && y_in;

  always_comb begin
    push_item.x     = x_pos[SCR_BITS-1:0];
    push_item.y     = y_pos[SCR_BITS-1:0];
    push_item.pixel = in_src_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      origin_x_r <= '0;
      origin_y_r <= '0;
      size_w_r   <= '0;
      size_h_r   <= '0;
      col_r      <= '0;
      row_r      <= '0;
    end else if (accept) begin
      if (in_req_type == REQ_START) begin
        origin_x_r <= in_pos_x;
        origin_y_r <= in_pos_y;
        size_w_r   <= in_bmp_width;
        size_h_r   <= in_bmp_height;
        col_r      <= '0;
        row_r      <= '0;
        active_r   <= (in_bmp_width != '0) && (in_bmp_height != '0);
      end else if (active_r) begin
        if (col_last) begin
          col_r <= '0;
          if (row_last) begin
            row_r    <= '0;
            active_r <= 1'b0;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/ctblit_queue.sv =====
// Short FIFO between the clipping front end and the address back end.
// Depends on ctblit_pkg for the entry type and depth.
module ctblit_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ctblit_pkg::wr_t push_item,
  output logic            full,
  input  logic            pop,
  output ctblit_pkg::wr_t head,
  output logic            empty
);
  import ctblit_pkg::*;

  wr_t                   mem_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_BITS-1:0] count_r;

  assign full  = (count_r == Q_CNT_BITS'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_BITS'(Q_DEPTH)) else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/ctblit_back.sv =====
// Back end: forms the destination address x + y * pitch and holds the output item.
// Depends on ctblit_pkg; pops entries from ctblit_queue.
module ctblit_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ctblit_pkg::cfg_t                   cfg,
  input  logic                               q_empty,
  input  ctblit_pkg::wr_t                    q_head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ctblit_pkg::ADDR_BITS-1:0]   out_write_address,
  output logic [ctblit_pkg::PIX_BITS-1:0]    out_write_data
);
  import ctblit_pkg::*;

  logic                 a_valid_r;
  logic [SCR_BITS-1:0]  a_x_r;
  logic [PIX_BITS-1:0]  a_pix_r;
  logic [PROD_BITS-1:0] a_prod_r;

  logic                 out_valid_r;
  logic [ADDR_BITS-1:0] out_addr_r;
  logic [PIX_BITS-1:0]  out_data_r;

  logic out_move, a_move;

  assign out_move = !out_valid_r || !out_stall;
  assign a_move   = !a_valid_r || out_move;
  assign pop      = !q_empty && a_move;

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;

  // stage A: row offset product
  always_ff @(posedge clk) begin
    if (pop) begin
      a_x_r    <= q_head.x;
      a_pix_r  <= q_head.pixel;
      a_prod_r <= {{PITCH_BITS{1'b0}}, q_head.y} * {{SCR_BITS{1'b0}}, cfg.dest_pitch};
    end
  end

  // output register: add column, wrap to address width
  always_ff @(posedge clk) begin
    if (out_move && a_valid_r) begin
      out_addr_r <= a_prod_r[ADDR_BITS-1:0] + {{(ADDR_BITS-SCR_BITS){1'b0}}, a_x_r};
      out_data_r <= a_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_move)   a_valid_r   <= pop;
      if (out_move) out_valid_r <= a_valid_r;
    end
  end

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_addr_r) && $stable(out_data_r)))
    else $error("output item changed under stall");

  a_nonzero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r != '0)) else $error("transparent pixel written");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !out_move) |=> (a_valid_r && $stable(a_prod_r)))
    else $error("stage A lost an item");

endmodule
